// ===== rtl/wpd_pkg.sv =====
// wpd_pkg: shared types and constants for the wire packet decoder
// no dependencies
`timescale 1ns / 1ps
package wpd_pkg;

    localparam int DECK_FIELDS = 7;
    localparam int FLAG_GROUP  = 8;

    typedef enum logic [4:0] {
        TAG_TIME    = 5'd0,
        TAG_HASH    = 5'd1,
        TAG_DECKA   = 5'd2,
        TAG_DECKB   = 5'd9,
        TAG_GEST    = 5'd16,
        TAG_COUNT   = 5'd17,
        TAG_VALUE   = 5'd18,
        TAG_KNOWN   = 5'd19,
        TAG_ENTRIES = 5'd20,
        TAG_EKIND   = 5'd21,
        TAG_ELEN    = 5'd22,
        TAG_EID     = 5'd23,
        TAG_STATUS  = 5'd24
    } tag_t;

    localparam logic [2:0] VERD_OK      = 3'd0;
    localparam logic [2:0] VERD_MAGIC   = 3'd1;
    localparam logic [2:0] VERD_VERSION = 3'd2;
    localparam logic [2:0] VERD_KIND    = 3'd3;
    localparam logic [2:0] VERD_SHORT   = 3'd4;

    localparam logic [1:0] REG_MAGIC   = 2'd0;
    localparam logic [1:0] REG_VERSION = 2'd1;
    localparam logic [1:0] REG_SKIND   = 2'd2;
    localparam logic [1:0] REG_CKIND   = 2'd3;

    // one result item
    typedef struct packed {
        logic [4:0]  tag;
        logic        cls;
        logic [15:0] elem;
        logic [7:0]  chpos;
        logic [63:0] value;
        logic [2:0]  verdict;
        logic        fin;
    } result_t;

    // up to two results per input byte, queued as one entry
    typedef struct packed {
        logic    has_field;
        logic    has_status;
        result_t field;
        result_t status;
    } work_t;

endpackage

// ===== rtl/wire_packet_decoder.sv =====
// wire_packet_decoder: byte-stream datagram decoder, top level
// a field's result is queued and leaves when earlier entries and m_tready allow
// one byte per cycle unless queue is full; a final byte closing a field gives two results
// reset: aresetn synchronous active low, resets parse state, queue and registers
// depends on wpd_pkg, wpd_parser, wpd_queue, wpd_emitter
`timescale 1ns / 1ps
module wire_packet_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_datagram
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // element_number, char_position, field_value, verdict, pad
    output logic [5:0]  m_tuser,   // field_tag, packet_class
    output logic        m_tlast    // final_flag
);
    import wpd_pkg::*;

    logic [31:0] magic_reg;
    logic [15:0] version_reg, skind_reg, ckind_reg;
    logic        in_go, pw_valid, q_nf, q_valid, q_ready;
    work_t       pw, qd;
    result_t     r;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg   <= '0;
            version_reg <= '0;
            skind_reg   <= '0;
            ckind_reg   <= 16'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAGIC:   magic_reg   <= cfg_data;
                REG_VERSION: version_reg <= cfg_data[15:0];
                REG_SKIND:   skind_reg   <= cfg_data[15:0];
                REG_CKIND:   ckind_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // a byte is taken whenever the queue has room
    assign s_tready = q_nf;
    assign in_go    = s_tvalid && q_nf;

    wpd_parser u_parser (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(in_go), .in_byte(s_tdata), .in_last(s_tlast),
        .magic_word(magic_reg), .version_word(version_reg),
        .state_kind_code(skind_reg), .schema_kind_code(ckind_reg),
        .work_valid(pw_valid), .work(pw)
    );

    wpd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(pw_valid), .wr_data(pw), .not_full(q_nf),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(qd)
    );

    wpd_emitter u_emitter (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_data(qd), .q_ready(q_ready),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(r)
    );

    assign m_tdata = {5'd0, r.verdict, r.value, r.chpos, r.elem};
    assign m_tuser = {r.cls, r.tag};
    assign m_tlast = r.fin;

endmodule

// ===== rtl/wpd_parser.sv =====
// wpd_parser: front end, assembles fields byte by byte and classifies them
// depends on wpd_pkg
`timescale 1ns / 1ps
module wpd_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  logic [31:0]           magic_word,
    input  logic [15:0]           version_word,
    input  logic [15:0]           state_kind_code,
    input  logic [15:0]           schema_kind_code,
    output logic                  work_valid,
    output wpd_pkg::work_t        work
);
    import wpd_pkg::*;

    typedef enum logic [4:0] {
        PH_MAGIC, PH_VERSION, PH_KIND, PH_TIME, PH_HASH, PH_DECKA, PH_DECKB,
        PH_GEST, PH_COUNT, PH_VALUES, PH_KNOWN, PH_SHASH, PH_SCOUNT,
        PH_EKIND, PH_ELEN, PH_EID, PH_DONE, PH_SILENT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  bif_reg, bif_next;
    logic [63:0] asm_reg, asm_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  idlen_reg, idlen_next;
    logic [7:0]  idpos_reg, idpos_next;
    logic [2:0]  err_reg, err_next;
    logic        cls_reg, cls_next;

    logic [2:0]  need_m1;
    logic [63:0] v;
    logic        done_field;
    logic [15:0] pos_inc;
    logic [15:0] nbytes;
    logic [15:0] left;
    logic [7:0]  kmask;
    work_t       w;

    always_comb begin
        unique case (phase_reg)
            PH_MAGIC, PH_HASH, PH_DECKA, PH_DECKB, PH_GEST, PH_VALUES,
            PH_SHASH:                        need_m1 = 3'd3;
            PH_VERSION, PH_KIND, PH_COUNT,
            PH_SCOUNT:                       need_m1 = 3'd1;
            PH_TIME:                         need_m1 = 3'd7;
            default:                         need_m1 = 3'd0;
        endcase
    end

    assign pos_inc = pos_reg + 16'd1;
    assign nbytes  = {3'd0, total_reg[15:3]} + {15'd0, |total_reg[2:0]};
    assign left    = total_reg - {pos_reg[12:0], 3'd0};
    always_comb begin
        kmask = 8'hff;
        if (left < 16'(FLAG_GROUP)) kmask = 8'hff >> (4'd8 - {1'b0, left[2:0]});
    end

    always_comb begin
        phase_next = phase_reg;
        bif_next   = bif_reg;
        asm_next   = asm_reg;
        total_next = total_reg;
        pos_next   = pos_reg;
        idlen_next = idlen_reg;
        idpos_next = idpos_reg;
        err_next   = err_reg;
        cls_next   = cls_reg;
        v          = asm_reg | ({56'd0, in_byte} << {bif_reg, 3'b000});
        done_field = 1'b0;
        w          = '0;
        w.field.cls = cls_reg;

        if (in_valid && phase_reg != PH_DONE && phase_reg != PH_SILENT) begin
            if (bif_reg >= need_m1) begin
                done_field = 1'b1;
                asm_next   = '0;
                bif_next   = '0;
            end else begin
                asm_next = v;
                bif_next = bif_reg + 3'd1;
            end
        end

        if (done_field) begin
            w.field.value = v;
            unique case (phase_reg)
                PH_MAGIC: begin
                    if (v[31:0] != magic_word) begin
                        err_next = VERD_MAGIC; phase_next = PH_SILENT;
                    end else phase_next = PH_VERSION;
                end
                PH_VERSION: begin
                    if (v[15:0] != version_word) begin
                        err_next = VERD_VERSION; phase_next = PH_SILENT;
                    end else phase_next = PH_KIND;
                end
                PH_KIND: begin
                    if (v[15:0] == state_kind_code) begin
                        cls_next = 1'b0; phase_next = PH_TIME;
                    end else if (v[15:0] == schema_kind_code) begin
                        cls_next = 1'b1; phase_next = PH_SHASH;
                    end else begin
                        err_next = VERD_KIND; phase_next = PH_SILENT;
                    end
                end
                PH_TIME: begin
                    w.has_field = 1'b1; w.field.tag = TAG_TIME; phase_next = PH_HASH;
                end
                PH_HASH: begin
                    w.has_field = 1'b1; w.field.tag = TAG_HASH;
                    pos_next = '0; phase_next = PH_DECKA;
                end
                PH_DECKA, PH_DECKB: begin
                    w.has_field = 1'b1;
                    w.field.tag = (phase_reg == PH_DECKA ? TAG_DECKA : TAG_DECKB)
                                  + pos_reg[4:0];
                    pos_next = pos_inc;
                    if (pos_inc >= 16'(DECK_FIELDS)) begin
                        pos_next   = '0;
                        phase_next = (phase_reg == PH_DECKA) ? PH_DECKB : PH_GEST;
                    end
                end
                PH_GEST: begin
                    w.has_field = 1'b1; w.field.tag = TAG_GEST; phase_next = PH_COUNT;
                end
                PH_COUNT, PH_SCOUNT: begin
                    w.has_field = 1'b1;
                    w.field.tag = (phase_reg == PH_COUNT) ? TAG_COUNT : TAG_ENTRIES;
                    total_next = v[15:0];
                    pos_next   = '0;
                    if (v[15:0] == 16'd0) phase_next = PH_DONE;
                    else phase_next = (phase_reg == PH_COUNT) ? PH_VALUES : PH_EKIND;
                end
                PH_VALUES: begin
                    w.has_field = 1'b1; w.field.tag = TAG_VALUE; w.field.elem = pos_reg;
                    pos_next = pos_inc;
                    if (pos_inc == total_reg) begin
                        pos_next = '0; phase_next = PH_KNOWN;
                    end
                end
                PH_KNOWN: begin
                    w.has_field = 1'b1; w.field.tag = TAG_KNOWN; w.field.elem = pos_reg;
                    w.field.value = {56'd0, v[7:0] & kmask};
                    pos_next = pos_inc;
                    if (pos_inc >= nbytes) phase_next = PH_DONE;
                end
                PH_SHASH: begin
                    w.has_field = 1'b1; w.field.tag = TAG_HASH; phase_next = PH_SCOUNT;
                end
                PH_EKIND: begin
                    w.has_field = 1'b1; w.field.tag = TAG_EKIND; w.field.elem = pos_reg;
                    phase_next = PH_ELEN;
                end
                PH_ELEN: begin
                    w.has_field = 1'b1; w.field.tag = TAG_ELEN; w.field.elem = pos_reg;
                    idlen_next = v[7:0];
                    idpos_next = '0;
                    if (v[7:0] == 8'd0) begin
                        pos_next   = pos_inc;
                        phase_next = (pos_inc == total_reg) ? PH_DONE : PH_EKIND;
                    end else phase_next = PH_EID;
                end
                PH_EID: begin
                    w.has_field = 1'b1; w.field.tag = TAG_EID; w.field.elem = pos_reg;
                    w.field.chpos = idpos_reg;
                    idpos_next = idpos_reg + 8'd1;
                    if (idpos_next == idlen_reg) begin
                        pos_next   = pos_inc;
                        phase_next = (pos_inc == total_reg) ? PH_DONE : PH_EKIND;
                    end
                end
                default: ;
            endcase
        end

        // status on the final byte sees the state after this byte
        if (in_valid && in_last) begin
            w.has_status     = 1'b1;
            w.status.tag     = TAG_STATUS;
            w.status.cls     = (err_next == VERD_OK) ? cls_next : 1'b0;
            w.status.verdict = (err_next == VERD_OK && phase_next != PH_DONE)
                               ? VERD_SHORT : err_next;
            w.status.fin     = 1'b1;
            phase_next = PH_MAGIC;
            bif_next   = '0;
            asm_next   = '0;
            total_next = '0;
            pos_next   = '0;
            idlen_next = '0;
            idpos_next = '0;
            err_next   = VERD_OK;
            cls_next   = 1'b0;
        end
    end

    assign work_valid = in_valid && (w.has_field || w.has_status);
    assign work       = w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;
            bif_reg   <= '0;
            asm_reg   <= '0;
            total_reg <= '0;
            pos_reg   <= '0;
            idlen_reg <= '0;
            idpos_reg <= '0;
            err_reg   <= VERD_OK;
            cls_reg   <= 1'b0;
        end else if (in_valid) begin
            phase_reg <= phase_next;
            bif_reg   <= bif_next;
            asm_reg   <= asm_next;
            total_reg <= total_next;
            pos_reg   <= pos_next;
            idlen_reg <= idlen_next;
            idpos_reg <= idpos_next;
            err_reg   <= err_next;
            cls_reg   <= cls_next;
        end
    end

endmodule

// ===== rtl/wpd_queue.sv =====
// wpd_queue: short fifo of work entries between parser and emitter
// depends on wpd_pkg
`timescale 1ns / 1ps
module wpd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    input  wpd_pkg::work_t  wr_data,
    output logic            not_full,
    output logic            rd_valid,
    input  logic            rd_ready,
    output wpd_pkg::work_t  rd_data
);
    import wpd_pkg::*;

    work_t      mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       do_wr, do_rd;

    assign not_full = (cnt_reg != 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && not_full;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) wp_reg <= wp_reg + 2'd1;
            if (do_rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, do_wr} - {2'd0, do_rd};
        end
    end

endmodule

// ===== rtl/wpd_emitter.sv =====
// wpd_emitter: back end, splits each work entry into one or two result transactions
// depends on wpd_pkg
`timescale 1ns / 1ps
module wpd_emitter (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  wpd_pkg::work_t  q_data,
    output logic            q_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output wpd_pkg::result_t out_data
);
    import wpd_pkg::*;

    logic    field_done_reg, field_done_next;
    logic    sel_field;

    // field result first, then status
    assign sel_field = q_data.has_field && !field_done_reg;
    assign out_valid = q_valid;
    assign out_data  = sel_field ? q_data.field : q_data.status;
    assign q_ready   = out_ready && !(sel_field && q_data.has_status);

    always_comb begin
        field_done_next = field_done_reg;
        if (q_valid && out_ready) field_done_next = !q_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) field_done_reg <= 1'b0;
        else          field_done_reg <= field_done_next;
    end

endmodule
